### hw/rtl/pfdrc_pkg.sv
// ----------------------------------------------------------------------------
// pfdrc_pkg
// Shared types and constants for the packet FIFO with duplicate filter and
// range count.
// ----------------------------------------------------------------------------
package pfdrc_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned OUT_ADDR_W = 16;
  localparam int unsigned OUT_TIME_W = 32;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CHUNK      = 8;
  localparam int unsigned CHUNK_PC_W = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD = 2'd0,
    OP_FWD = 2'd1,
    OP_CNT = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUM
  } state_t;

  // Per-cell control: load takes the new packet, shift takes the right neighbor.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### hw/rtl/pfdrc_cell.sv
// ----------------------------------------------------------------------------
// pfdrc_cell
// One entry of the shifting packet row, with its duplicate and range match.
// ----------------------------------------------------------------------------
module pfdrc_cell #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfdrc_pkg::cell_ctrl_t ctrl,
  input  logic                  nb_valid,
  input  logic [ADDR_BITS-1:0]  nb_src,
  input  logic [ADDR_BITS-1:0]  nb_dst,
  input  logic [TIME_BITS-1:0]  nb_ts,
  input  logic [ADDR_BITS-1:0]  req_src,
  input  logic [ADDR_BITS-1:0]  req_dst,
  input  logic [TIME_BITS-1:0]  req_ts,
  input  logic [TIME_BITS-1:0]  req_lo,
  input  logic [TIME_BITS-1:0]  req_hi,
  output logic                  q_valid,
  output logic [ADDR_BITS-1:0]  q_src,
  output logic [ADDR_BITS-1:0]  q_dst,
  output logic [TIME_BITS-1:0]  q_ts,
  output logic                  dup_hit,
  output logic                  cnt_hit
);

  logic                 valid_r;
  logic [ADDR_BITS-1:0] src_r;
  logic [ADDR_BITS-1:0] dst_r;
  logic [TIME_BITS-1:0] ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.load) begin
      valid_r <= 1'b1;
    end else if (ctrl.shift) begin
      valid_r <= nb_valid;
    end
  end

  // Payload: load wins over shift.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      src_r <= req_src;
      dst_r <= req_dst;
      ts_r  <= req_ts;
    end else if (ctrl.shift) begin
      src_r <= nb_src;
      dst_r <= nb_dst;
      ts_r  <= nb_ts;
    end
  end

  assign q_valid = valid_r;
  assign q_src   = src_r;
  assign q_dst   = dst_r;
  assign q_ts    = ts_r;

  assign dup_hit = valid_r && (src_r == req_src) && (dst_r == req_dst) && (ts_r == req_ts);
  assign cnt_hit = valid_r && (dst_r == req_dst) && (ts_r >= req_lo) && (ts_r <= req_hi);

endmodule

### hw/rtl/pfdrc_count.sv
// ----------------------------------------------------------------------------
// pfdrc_count
// Sums the per-cell range hits, one chunk of cells per cycle.
// ----------------------------------------------------------------------------
module pfdrc_count #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [DEPTH-1:0]               hits,
  output logic                           done,
  output logic [pfdrc_pkg::COUNT_W-1:0]  sum
);

  localparam int unsigned NCHUNK = (DEPTH + pfdrc_pkg::CHUNK - 1) / pfdrc_pkg::CHUNK;
  localparam int unsigned PAD_W  = NCHUNK * pfdrc_pkg::CHUNK;
  localparam int unsigned IDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned SUM_W  = $clog2(DEPTH + 1);

  logic [PAD_W-1:0]                    hits_pad;
  logic [pfdrc_pkg::CHUNK-1:0]         chunk;
  logic [pfdrc_pkg::CHUNK_PC_W-1:0]    chunk_pc;
  logic [IDX_W-1:0]                    idx_r, idx_nxt;
  logic [SUM_W-1:0]                    acc_r, acc_nxt;
  logic                                run_r, run_nxt;
  logic                                done_r, done_nxt;
  logic                                last;

  assign hits_pad = PAD_W'(hits);
  assign chunk    = hits_pad[idx_r * pfdrc_pkg::CHUNK +: pfdrc_pkg::CHUNK];
  assign last     = (idx_r == IDX_W'(NCHUNK - 1));

  always_comb begin
    chunk_pc = '0;
    for (int k = 0; k < pfdrc_pkg::CHUNK; k++) begin
      chunk_pc = chunk_pc + pfdrc_pkg::CHUNK_PC_W'(chunk[k]);
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      idx_nxt  = '0;
      acc_nxt  = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      acc_nxt = acc_r + SUM_W'(chunk_pc);
      idx_nxt = idx_r + IDX_W'(1);
      if (last) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign sum  = pfdrc_pkg::COUNT_W'(acc_r);

endmodule

### hw/rtl/packet_fifo_dedup_range_count.sv
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count
// Bounded packet FIFO built as a shifting row of entry cells, with a
// duplicate filter on add and a destination / time-range count.
// ----------------------------------------------------------------------------
//
//   channel | ports                      | moves
//   --------+----------------------------+-----------------------------------
//   in      | in_valid / in_ready        | one operation per transfer
//   out     | out_valid / out_ready      | one result per operation
//   cfg     | cfg_wr_en / cfg_wr_data    | capacity write, no wait
//
// Add, forward and no-op: the transfer latches the request, then the exec
// state compares it against every cell and shifts or loads the row. Count:
// the hit bits of all cells are summed 8 cells per cycle by the counter. A
// new operation is taken while a result still sits in the output register;
// execution holds until that slot frees up. Reset (synchronous, active low)
// empties the row and sets the capacity to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module packet_fifo_dedup_range_count #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [pfdrc_pkg::CAP_W-1:0]       cfg_wr_data,
  // operation in
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pfdrc_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [ADDR_BITS-1:0]              in_source,
  input  logic [ADDR_BITS-1:0]              in_destination,
  input  logic [TIME_BITS-1:0]              in_timestamp,
  input  logic [TIME_BITS-1:0]              in_range_start,
  input  logic [TIME_BITS-1:0]              in_range_end,
  // result out
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accepted,
  output logic                              out_forward_valid,
  output logic [pfdrc_pkg::OUT_ADDR_W-1:0]  out_source,
  output logic [pfdrc_pkg::OUT_ADDR_W-1:0]  out_destination,
  output logic [pfdrc_pkg::OUT_TIME_W-1:0]  out_timestamp,
  output logic [pfdrc_pkg::COUNT_W-1:0]     out_match_count
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > pfdrc_pkg::CAP_W) ? OCC_W : pfdrc_pkg::CAP_W;

  // --------------------------------------------------------------------------
  // Capacity register and its effective value (zero acts as one, clamp to DEPTH)
  // --------------------------------------------------------------------------
  logic [pfdrc_pkg::CAP_W-1:0] cap_r;
  logic [CMP_W-1:0]            cap_ext;
  logic [CMP_W-1:0]            eff_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= pfdrc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  assign cap_ext = CMP_W'(cap_r);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Request registers: hold the operation taken on the input transfer
  // --------------------------------------------------------------------------
  pfdrc_pkg::op_t       req_op_r;
  logic [ADDR_BITS-1:0] req_src_r;
  logic [ADDR_BITS-1:0] req_dst_r;
  logic [TIME_BITS-1:0] req_ts_r;
  logic [TIME_BITS-1:0] req_lo_r;
  logic [TIME_BITS-1:0] req_hi_r;
  logic                 in_xfer;

  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op_r  <= pfdrc_pkg::op_t'(in_opcode);
      req_src_r <= in_source;
      req_dst_r <= in_destination;
      req_ts_r  <= in_timestamp;
      req_lo_r  <= in_range_start;
      req_hi_r  <= in_range_end;
    end
  end

  // --------------------------------------------------------------------------
  // Row of entry cells; cell 0 holds the oldest packet
  // --------------------------------------------------------------------------
  pfdrc_pkg::cell_ctrl_t      ctrl      [DEPTH];
  logic                       c_valid   [DEPTH];
  logic [ADDR_BITS-1:0]       c_src     [DEPTH];
  logic [ADDR_BITS-1:0]       c_dst     [DEPTH];
  logic [TIME_BITS-1:0]       c_ts      [DEPTH];
  logic [DEPTH-1:0]           dup_hits;
  logic [DEPTH-1:0]           cnt_hits;
  logic                       do_shift;
  logic                       do_load;
  logic [OCC_W-1:0]           load_idx;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 nb_valid;
    logic [ADDR_BITS-1:0] nb_src;
    logic [ADDR_BITS-1:0] nb_dst;
    logic [TIME_BITS-1:0] nb_ts;

    // The last cell shifts in an empty slot.
    if (i == DEPTH - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_src   = '0;
      assign nb_dst   = '0;
      assign nb_ts    = '0;
    end else begin : g_link
      assign nb_valid = c_valid[i+1];
      assign nb_src   = c_src[i+1];
      assign nb_dst   = c_dst[i+1];
      assign nb_ts    = c_ts[i+1];
    end

    assign ctrl[i].shift = do_shift;
    assign ctrl[i].load  = do_load && (load_idx == OCC_W'(i));

    pfdrc_cell #(
      .ADDR_BITS (ADDR_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[i]),
      .nb_valid (nb_valid),
      .nb_src   (nb_src),
      .nb_dst   (nb_dst),
      .nb_ts    (nb_ts),
      .req_src  (req_src_r),
      .req_dst  (req_dst_r),
      .req_ts   (req_ts_r),
      .req_lo   (req_lo_r),
      .req_hi   (req_hi_r),
      .q_valid  (c_valid[i]),
      .q_src    (c_src[i]),
      .q_dst    (c_dst[i]),
      .q_ts     (c_ts[i]),
      .dup_hit  (dup_hits[i]),
      .cnt_hit  (cnt_hits[i])
    );
  end

  // --------------------------------------------------------------------------
  // Range counter
  // --------------------------------------------------------------------------
  logic                          cnt_start;
  logic                          cnt_done;
  logic [pfdrc_pkg::COUNT_W-1:0] cnt_sum;

  pfdrc_count #(
    .DEPTH (DEPTH)
  ) u_count (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cnt_start),
    .hits  (cnt_hits),
    .done  (cnt_done),
    .sum   (cnt_sum)
  );

  // --------------------------------------------------------------------------
  // Control: occupancy, sequencer and output register
  // --------------------------------------------------------------------------
  pfdrc_pkg::state_t               state_r, state_nxt;
  logic [OCC_W-1:0]                occ_r, occ_nxt;
  logic                            full;
  logic                            dup;
  logic                            slot_free;
  logic                            res_wr;

  logic                            out_valid_r, out_valid_nxt;
  logic                            acc_r, acc_nxt;
  logic                            fwd_r, fwd_nxt;
  logic [pfdrc_pkg::OUT_ADDR_W-1:0] src_r, src_nxt;
  logic [pfdrc_pkg::OUT_ADDR_W-1:0] dst_r, dst_nxt;
  logic [pfdrc_pkg::OUT_TIME_W-1:0] ts_r, ts_nxt;
  logic [pfdrc_pkg::COUNT_W-1:0]    cnt_r, cnt_nxt;

  assign full      = CMP_W'(occ_r) >= eff_cap;
  assign dup       = |dup_hits;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == pfdrc_pkg::ST_IDLE);

  // When full, the oldest drops and the new packet lands one cell lower.
  assign load_idx = full ? (occ_r - OCC_W'(1)) : occ_r;

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    do_shift  = 1'b0;
    do_load   = 1'b0;
    cnt_start = 1'b0;
    res_wr    = 1'b0;
    acc_nxt   = acc_r;
    fwd_nxt   = fwd_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ts_nxt    = ts_r;
    cnt_nxt   = cnt_r;

    unique case (state_r)
      pfdrc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = pfdrc_pkg::ST_EXEC;
        end
      end

      pfdrc_pkg::ST_EXEC: begin
        if (req_op_r == pfdrc_pkg::OP_CNT) begin
          // Hits are stable from here on; sum them over the next cycles.
          cnt_start = 1'b1;
          state_nxt = pfdrc_pkg::ST_SUM;
        end else if (slot_free) begin
          res_wr    = 1'b1;
          state_nxt = pfdrc_pkg::ST_IDLE;
          acc_nxt   = 1'b0;
          fwd_nxt   = 1'b0;
          src_nxt   = '0;
          dst_nxt   = '0;
          ts_nxt    = '0;
          cnt_nxt   = '0;
          case (req_op_r)
            pfdrc_pkg::OP_ADD: begin
              if (!dup) begin
                acc_nxt = 1'b1;
                do_load = 1'b1;
                if (full) begin
                  do_shift = 1'b1;
                end else begin
                  occ_nxt = occ_r + OCC_W'(1);
                end
              end
            end
            pfdrc_pkg::OP_FWD: begin
              if (occ_r != '0) begin
                fwd_nxt  = 1'b1;
                src_nxt  = pfdrc_pkg::OUT_ADDR_W'(c_src[0]);
                dst_nxt  = pfdrc_pkg::OUT_ADDR_W'(c_dst[0]);
                ts_nxt   = pfdrc_pkg::OUT_TIME_W'(c_ts[0]);
                do_shift = 1'b1;
                occ_nxt  = occ_r - OCC_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      pfdrc_pkg::ST_SUM: begin
        if (cnt_done && slot_free) begin
          res_wr    = 1'b1;
          state_nxt = pfdrc_pkg::ST_IDLE;
          acc_nxt   = 1'b0;
          fwd_nxt   = 1'b0;
          src_nxt   = '0;
          dst_nxt   = '0;
          ts_nxt    = '0;
          cnt_nxt   = cnt_sum;
        end
      end

      default: begin
        state_nxt = pfdrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfdrc_pkg::ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset, qualified by out_valid.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    fwd_r <= fwd_nxt;
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    ts_r  <= ts_nxt;
    cnt_r <= cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_forward_valid = fwd_r;
  assign out_source        = src_r;
  assign out_destination   = dst_r;
  assign out_timestamp     = ts_r;
  assign out_match_count   = cnt_r;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the packet FIFO with duplicate filter and range count. Directed
// tests cover the empty buffer, field extremes, refused duplicates, inverted
// ranges and the capacity corner cases. Random traffic then runs under
// several capacity settings and idle / stall patterns. Every result is
// compared field by field against a local model of the shifting row.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ROW_DEPTH = 64;

  typedef logic [pfdrc_pkg::OUT_ADDR_W-1:0] addr_t;
  typedef logic [pfdrc_pkg::OUT_TIME_W-1:0] stamp_t;

  typedef struct packed {
    logic                            accepted;
    logic                            forward_valid;
    addr_t                           source;
    addr_t                           destination;
    stamp_t                          timestamp;
    logic [pfdrc_pkg::COUNT_W-1:0]   match_count;
  } op_result_t;

  typedef struct packed {
    addr_t  source;
    addr_t  destination;
    stamp_t timestamp;
  } packet_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [pfdrc_pkg::CAP_W-1:0]    cfg_wr_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [pfdrc_pkg::OPCODE_W-1:0] in_opcode;
  addr_t                          in_source;
  addr_t                          in_destination;
  stamp_t                         in_timestamp;
  stamp_t                         in_range_start;
  stamp_t                         in_range_end;
  logic                           out_valid;
  logic                           out_ready;
  logic                           out_accepted;
  logic                           out_forward_valid;
  addr_t                          out_source;
  addr_t                          out_destination;
  stamp_t                         out_timestamp;
  logic [pfdrc_pkg::COUNT_W-1:0]  out_match_count;

  // Model of the row: oldest packet in slot 0, next free slot at held_count.
  addr_t                       held_src [ROW_DEPTH];
  addr_t                       held_dst [ROW_DEPTH];
  stamp_t                      held_ts  [ROW_DEPTH];
  int unsigned                 held_count;
  logic [pfdrc_pkg::CAP_W-1:0] cap_setting;

  op_result_t  pending_results[$];
  packet_t     recent_packets[$];
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;

  packet_fifo_dedup_range_count dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_source         (in_source),
    .in_destination    (in_destination),
    .in_timestamp      (in_timestamp),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_forward_valid (out_forward_valid),
    .out_source        (out_source),
    .out_destination   (out_destination),
    .out_timestamp     (out_timestamp),
    .out_match_count   (out_match_count)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Row model
  // --------------------------------------------------------------------------

  // Shift every held packet one slot toward the head and free the last one.
  function automatic void drop_oldest_packet();
    if (held_count == 0) return;
    for (int unsigned i = 0; i + 1 < held_count; i++) begin
      held_src[i] = held_src[i+1];
      held_dst[i] = held_dst[i+1];
      held_ts[i]  = held_ts[i+1];
    end
    held_count--;
  endfunction

  // Apply one operation to the model row and return the result it yields.
  function automatic op_result_t apply_packet_op(pfdrc_pkg::op_t op, addr_t src, addr_t dst,
                                                  stamp_t ts, stamp_t lo, stamp_t hi);
    op_result_t  res;
    bit          dup;
    int unsigned limit;
    int unsigned hits;
    res = '0;
    case (op)
      pfdrc_pkg::OP_ADD: begin
        dup = 1'b0;
        for (int unsigned i = 0; i < held_count; i++) begin
          if (held_src[i] == src && held_dst[i] == dst && held_ts[i] == ts) dup = 1'b1;
        end
        // A duplicate is refused before anything is dropped, even when full.
        if (!dup) begin
          if (cap_setting == 0) limit = 1;
          else if (cap_setting > ROW_DEPTH) limit = ROW_DEPTH;
          else limit = 32'(cap_setting);
          // Drop only one packet, even when capacity sits below occupancy.
          if (held_count >= limit) drop_oldest_packet();
          if (held_count < ROW_DEPTH) begin
            held_src[held_count] = src;
            held_dst[held_count] = dst;
            held_ts[held_count]  = ts;
            held_count++;
          end
          res.accepted = 1'b1;
        end
      end
      pfdrc_pkg::OP_FWD: begin
        if (held_count > 0) begin
          res.forward_valid = 1'b1;
          res.source        = held_src[0];
          res.destination   = held_dst[0];
          res.timestamp     = held_ts[0];
          drop_oldest_packet();
        end
      end
      pfdrc_pkg::OP_CNT: begin
        // An inverted range matches nothing, so it counts zero by itself.
        hits = 0;
        for (int unsigned i = 0; i < held_count; i++) begin
          if (held_dst[i] == dst && held_ts[i] >= lo && held_ts[i] <= hi) hits++;
        end
        res.match_count = hits[pfdrc_pkg::COUNT_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    op_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted",        32'(want.accepted),      32'(out_accepted));
        check_field("forward_valid",   32'(want.forward_valid), 32'(out_forward_valid));
        check_field("out_source",      32'(want.source),        32'(out_source));
        check_field("out_destination", 32'(want.destination),   32'(out_destination));
        check_field("out_timestamp",   want.timestamp,          out_timestamp);
        check_field("match_count",     32'(want.match_count),   32'(out_match_count));
      end
    end
  end

  // Stall the result channel at the rate of the current phase.
  always @(negedge clk) begin
    out_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Hold until every issued operation has returned its result.
  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write the capacity register while the block is idle.
  task automatic write_capacity(logic [pfdrc_pkg::CAP_W-1:0] value);
    wait_for_results();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cap_setting = value;
  endtask

  // Send one operation: idle first at the phase rate, then hold valid and
  // payload until the transfer, and record the expected result.
  task automatic send_op(pfdrc_pkg::op_t op, addr_t src, addr_t dst, stamp_t ts,
                         stamp_t lo, stamp_t hi);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_source      = src;
    in_destination = dst;
    in_timestamp   = ts;
    in_range_start = lo;
    in_range_end   = hi;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_packet_op(op, src, dst, ts, lo, hi));
    @(negedge clk);
    // Drop valid; a following send raises it again at this same edge.
    in_valid = 1'b0;
  endtask

  // Build one random operation. Adds draw from small value pools or the full
  // range, or replay a recent packet so duplicates and count hits come up often.
  task automatic send_random_op(int unsigned add_pct);
    int unsigned pick;
    int unsigned span;
    packet_t     pkt;
    stamp_t      lo;
    stamp_t      hi;
    stamp_t      tmp;
    pick = $urandom_range(99);
    span = 100 - add_pct;
    lo   = $urandom;
    hi   = $urandom;
    if (pick < add_pct) begin
      if (recent_packets.size() != 0 && $urandom_range(3) == 0) begin
        pkt = recent_packets[$urandom_range(recent_packets.size() - 1)];
      end else if ($urandom_range(3) == 0) begin
        pkt.source      = 16'($urandom_range(16'hFFFF));
        pkt.destination = 16'($urandom_range(16'hFFFF));
        pkt.timestamp   = $urandom;
      end else begin
        pkt.source      = 16'($urandom_range(3));
        pkt.destination = 16'($urandom_range(3));
        pkt.timestamp   = $urandom_range(31);
      end
      recent_packets.push_back(pkt);
      if (recent_packets.size() > 16) void'(recent_packets.pop_front());
      send_op(pfdrc_pkg::OP_ADD, pkt.source, pkt.destination, pkt.timestamp, lo, hi);
    end else if (pick - add_pct < span * 2 / 5) begin
      send_op(pfdrc_pkg::OP_FWD, 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(16'hFFFF)), $urandom, lo, hi);
    end else if (pick - add_pct < span * 9 / 10) begin
      if (recent_packets.size() != 0 && $urandom_range(3) != 0)
        pkt = recent_packets[$urandom_range(recent_packets.size() - 1)];
      else
        pkt = {16'($urandom_range(16'hFFFF)), 16'($urandom_range(3)), 32'($urandom)};
      case ($urandom_range(3))
        0: begin
          lo = '0;
          hi = '1;
        end
        1: begin
          lo = $urandom_range(31);
          hi = $urandom_range(31);
          if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
        2: begin
          // Invert the window: start strictly after end.
          hi = $urandom_range(30);
          lo = hi + 1 + $urandom_range(4);
        end
        default: ;
      endcase
      send_op(pfdrc_pkg::OP_CNT, 16'($urandom_range(16'hFFFF)), pkt.destination,
              $urandom, lo, hi);
    end else begin
      send_op(pfdrc_pkg::OP_NOP, 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(16'hFFFF)), $urandom, lo, hi);
    end
  endtask

  // One random phase: capacity setting, idle and stall pattern, add share and
  // item count. With pause set, the sender stops halfway, and now and then at random, until all results are back.
  task automatic run_random_phase(logic [pfdrc_pkg::CAP_W-1:0] cap, int unsigned idle_pct,
                                  int unsigned stall_pct, int unsigned count,
                                  int unsigned add_pct, bit pause);
    write_capacity(cap);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (pause && (i == count / 2 || $urandom_range(49) == 0)) wait_for_results();
      send_random_op(add_pct);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Forward and count on an empty buffer, and the no-op code.
  task automatic test_empty_buffer();
    send_op(pfdrc_pkg::OP_FWD, '1, '1, '1, '0, '1);
    send_op(pfdrc_pkg::OP_CNT, '0, '0, '0, '0, '1);
    send_op(pfdrc_pkg::OP_NOP, '1, '1, '1, '1, '1);
  endtask

  // All-zero and all-one packets, a refused duplicate, a mixed bit pattern.
  task automatic test_add_extremes();
    send_op(pfdrc_pkg::OP_ADD, '0, '0, '0, '0, '0);
    send_op(pfdrc_pkg::OP_ADD, '1, '1, '1, '1, '1);
    send_op(pfdrc_pkg::OP_ADD, '1, '1, '1, '0, '0);
    send_op(pfdrc_pkg::OP_ADD, 16'hAAAA, 16'h5555, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
            32'hC3C3_C3C3);
  endtask

  // Full window, inverted window, and a single-point window at zero.
  task automatic test_count_ranges();
    send_op(pfdrc_pkg::OP_CNT, '0, '1, '0, '0, '1);
    send_op(pfdrc_pkg::OP_CNT, '0, '1, '0, '1, '0);
    send_op(pfdrc_pkg::OP_CNT, '1, '0, '1, '0, '0);
  endtask

  // Lower capacity below occupancy: an add drops one packet only. Then
  // drain the row by forwards and forward once more on empty.
  task automatic test_capacity_shrink();
    write_capacity(7'd1);
    send_op(pfdrc_pkg::OP_ADD, 16'h1234, 16'h5678, 32'h0000_0042, '0, '0);
    repeat (4) send_op(pfdrc_pkg::OP_FWD, '0, '0, '0, '0, '0);
  endtask

  // Capacity zero holds one packet; a duplicate while full drops nothing.
  task automatic test_capacity_zero();
    write_capacity(7'd0);
    send_op(pfdrc_pkg::OP_ADD, 16'h0001, 16'h0002, 32'h0000_0003, '0, '0);
    send_op(pfdrc_pkg::OP_ADD, 16'h0004, 16'h0005, 32'h0000_0006, '0, '0);
    send_op(pfdrc_pkg::OP_ADD, 16'h0004, 16'h0005, 32'h0000_0006, '0, '0);
    send_op(pfdrc_pkg::OP_FWD, '0, '0, '0, '0, '0);
    send_op(pfdrc_pkg::OP_FWD, '0, '0, '0, '0, '0);
  endtask

  // Capacity above the row depth: fill past 64 so the row itself overflows.
  task automatic test_overflow_above_depth();
    run_random_phase(7'd127, 0, 0, 60, 95, 1'b0);
    run_random_phase(7'd65, 49, 0, 40, 80, 1'b0);
  endtask

  // Mixed random traffic across capacities and idle patterns.
  task automatic test_random_mix();
    run_random_phase(7'd64, 0, 0, 80, 55, 1'b0);
    run_random_phase(7'd5, 0, 49, 80, 55, 1'b1);
    run_random_phase(7'd1, 30, 30, 60, 60, 1'b0);
    run_random_phase(7'd33, 49, 49, 80, 60, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_opcode       = pfdrc_pkg::OP_NOP;
    in_source       = '0;
    in_destination  = '0;
    in_timestamp    = '0;
    in_range_start  = '0;
    in_range_end    = '0;
    out_ready       = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    held_count      = 0;
    cap_setting     = pfdrc_pkg::CAP_RESET;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_buffer();
    test_add_extremes();
    test_count_ranges();
    test_capacity_shrink();
    test_capacity_zero();
    test_overflow_above_depth();
    test_random_mix();

    // Drop valid, collect the remaining results, then allow a count's
    // worth of cycles for any stray transfer.
    in_valid = 1'b0;
    wait_for_results();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS packet_fifo_dedup_range_count");
    end else begin
      $display("FAIL packet_fifo_dedup_range_count");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL packet_fifo_dedup_range_count");
    $finish;
  end

endmodule
